/* src/bvde_pkg.sv */
// Shared types, constants and helpers for the Butler-Volmer dissipation evaluator.
// No dependencies; every other file refers to it by scoped names.
package bvde_pkg;

   localparam logic [20:0] LIMIT_CAP = 21'd1310720;
   localparam logic [32:0] LOG2E_Q30 = 33'd1549082005;

   localparam logic [31:0] POLY [0:9] = '{
      32'd1073741824, 32'd744261118, 32'd257941248, 32'd59597083, 32'd10327387,
      32'd1431680, 32'd165394, 32'd16378, 32'd1419, 32'd109
   };

   typedef enum logic [2:0] {
      CSR_ALPHA_FRAC          = 3'd0,
      CSR_INV_ALPHA           = 3'd1,
      CSR_INV_ONE_MINUS_ALPHA = 3'd2,
      CSR_THERMAL_SCALE       = 3'd3,
      CSR_INV_THERMAL_SCALE   = 3'd4,
      CSR_EXCHANGE_CURRENT    = 3'd5,
      CSR_LINEAR_LIMIT        = 3'd6,
      CSR_TIME_STEP           = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_INSIDE = 2'd0,
      REGION_ABOVE  = 2'd1,
      REGION_BELOW  = 2'd2
   } region_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic               sat;
   } sat_word_type;

   function automatic sat_word_type add_sat(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
      logic signed [64:0] sum;
      sat_word_type       r;
      sum   = {a[63], a} + {b[63], b};
      r.sat = sum[64] ^ sum[63];
      if (r.sat) begin
         r.value = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         r.value = sum[63:0];
      end
      return r;
   endfunction

endpackage

/* src/bvde_mul_sat.sv */
// Two-stage signed 64x64 multiply with right shift, truncation toward zero and
// saturation to 64 bits. Uses bvde_pkg for the result type.
module bvde_mul_sat (
   input  logic                   clock,
   input  logic                   enable,
   input  logic signed [63:0]     op_a,
   input  logic signed [63:0]     op_b,
   input  logic [5:0]             shift,
   output bvde_pkg::sat_word_type result
);

   logic [63:0]  mag_a;
   logic [63:0]  mag_b;
   logic [63:0]  pp0_ff, pp1_ff, pp2_ff, pp3_ff;
   logic         neg_ff;
   logic [127:0] full;
   logic [127:0] shifted;
   logic [127:0] lim;
   logic         over;
   logic [63:0]  mag;
   bvde_pkg::sat_word_type result_in;
   bvde_pkg::sat_word_type result_ff;

   assign mag_a = op_a[63] ? (~op_a + 64'd1) : op_a;
   assign mag_b = op_b[63] ? (~op_b + 64'd1) : op_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         pp0_ff <= 64'(mag_a[31:0]) * 64'(mag_b[31:0]);
         pp1_ff <= 64'(mag_a[31:0]) * 64'(mag_b[63:32]);
         pp2_ff <= 64'(mag_a[63:32]) * 64'(mag_b[31:0]);
         pp3_ff <= 64'(mag_a[63:32]) * 64'(mag_b[63:32]);
         neg_ff <= op_a[63] ^ op_b[63];
      end
   end

   always_comb begin
      full = {64'd0, pp0_ff} + {32'd0, pp1_ff, 32'd0} + {32'd0, pp2_ff, 32'd0}
           + {pp3_ff, 64'd0};
      shifted = full >> shift;
      lim = {64'd0, neg_ff, {63{~neg_ff}}};
      over = shifted > lim;
      mag = over ? lim[63:0] : shifted[63:0];
      result_in.value = neg_ff ? -$signed(mag) : $signed(mag);
      result_in.sat = over;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* src/bvde_exp_unit.sv */
// Pipelined fixed-point exponential: base-2 conversion, nine Horner stages and
// a final scale shift; eleven register stages. Uses bvde_pkg constants.
module bvde_exp_unit #(
   parameter int EXP_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [39:0] arg,
   output logic [63:0]        value
);

   localparam int STEPS = 9;
   localparam int DROP_BITS = 32 - EXP_FRAC_BITS;
   localparam logic [63:0] KEEP_MASK = ~((64'd1 << DROP_BITS) - 64'd1);

   logic signed [31:0] arg_q24;
   logic signed [64:0] scaled;
   logic signed [9:0]  k_ff [0:STEPS];
   logic [29:0]        f_ff [0:STEPS-1];
   logic [31:0]        p_ff [0:STEPS-1];
   logic signed [9:0]  sh;
   logic [9:0]         nsh;
   logic [63:0]        e;
   logic [63:0]        value_in;
   logic [63:0]        value_ff;

   assign arg_q24 = 32'(arg >>> 8);
   assign scaled = 65'(arg_q24) * 65'($signed(bvde_pkg::LOG2E_Q30));

   always_ff @(posedge clock) begin
      if (enable) begin
         k_ff[0] <= scaled[63:54];
         f_ff[0] <= scaled[53:24];
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_horner
      logic [31:0] p_prev;
      logic [61:0] prod;
      logic [31:0] p_in;
      if (s == 0) begin : g_first
         assign p_prev = bvde_pkg::POLY[STEPS];
      end else begin : g_next
         assign p_prev = p_ff[s-1];
      end
      assign prod = 62'(p_prev) * 62'(f_ff[s]);
      assign p_in = bvde_pkg::POLY[STEPS-1-s] + prod[61:30];
      always_ff @(posedge clock) begin
         if (enable) begin
            p_ff[s]   <= p_in;
            k_ff[s+1] <= k_ff[s];
         end
      end
      if (s < STEPS - 1) begin : g_frac
         always_ff @(posedge clock) begin
            if (enable) begin
               f_ff[s+1] <= f_ff[s];
            end
         end
      end
   end

   always_comb begin
      sh = k_ff[STEPS] + 10'sd2;
      nsh = 10'(-sh);
      if (!sh[9]) begin
         e = 64'(p_ff[STEPS-1]) << sh[5:0];
      end else if (nsh > 10'd63) begin
         e = 64'd0;
      end else begin
         e = 64'(p_ff[STEPS-1]) >> nsh[5:0];
      end
      value_in = e & KEEP_MASK;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

/* src/butler_volmer_dissipation_eval_unit.sv */
// Butler-Volmer dual dissipation evaluator. One overpotential sample is taken per
// clock unless the result side stalls; its value, first and second derivative
// leave the pipeline, whose depth is set by the nine Horner stages of the
// exponential and the two-stage 64-bit multipliers of the extension and scaling.
// A stall on the result side freezes every datapath stage at once. The scale factors are
// formed from the registers by a free-running chain (product, multipliers, factor
// registers), so let a register write pass through that whole chain before the next transfer.
// Depends on bvde_pkg, bvde_mul_sat and bvde_exp_unit.
module butler_volmer_dissipation_eval_unit #(
   parameter int EXP_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_overpotential,
   input  logic [2:0]         req_want_mask,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_potential_value,
   output logic signed [63:0] rsp_first_derivative,
   output logic signed [63:0] rsp_second_derivative,
   output logic [1:0]         rsp_region,
   output logic               rsp_saturated
);

   localparam int LAST = 22;

   // configuration
   logic [15:0] alpha_ff;
   logic [31:0] inv_alpha_ff;
   logic [31:0] inv_oma_ff;
   logic [30:0] rt_ff;
   logic [30:0] inv_rt_ff;
   logic [30:0] i0_ff;
   logic [20:0] limit_ff;
   logic [30:0] dt_ff;

   logic adv;
   logic vld_ff [1:LAST];
   logic [2:0] mask_ff [1:LAST];
   logic [1:0] region_ff [2:LAST];
   logic signed [63:0] d_ff [2:17];

   logic signed [62:0] x_in, x_ff;
   logic [20:0] lim;
   logic signed [63:0] edge_pos, edge_neg, x_ext;
   logic signed [63:0] u_in, d_in, u_ff;
   logic [1:0] region_in;

   logic u_neg;
   logic signed [63:0] u_abs;
   logic [36:0] u_mag;
   logic [16:0] cm;
   logic [52:0] pa1;
   logic [53:0] pa2;
   logic signed [39:0] a1_in, a2_in, a1_ff, a2_ff;

   logic [63:0] e1, e2;
   logic [79:0] pg1, pg2;
   logic signed [63:0] g2_in, diff_in;
   logic signed [63:0] g2_ff [15:20];
   logic signed [63:0] diff_ff [15:17];
   logic signed [63:0] base_ff, g0_ff;
   logic signed [63:0] g0a_ff [18:19];
   logic signed [63:0] g1_ff [18:20];
   logic f0_ff [17:LAST];
   logic f1_ff [18:LAST];

   bvde_pkg::sat_word_type b1, b2, slope, diffd, half, fin0, fin1, fin2, sc0, sc2;
   bvde_pkg::sat_word_type bsum, g1s, g0as, g0s;

   logic [61:0] pr_ff;
   logic signed [63:0] pr_s;
   logic signed [63:0] s0_ff, s1_ff, s2_ff;
   logic s0f_ff, s2f_ff;

   logic rsp_valid_ff;
   logic signed [63:0] r0_ff, r1_ff, r2_ff;
   logic [1:0] rregion_ff;
   logic rsat_ff, sat_in;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= 16'd32768;
         inv_alpha_ff <= 32'd131072;
         inv_oma_ff   <= 32'd131072;
         rt_ff        <= 31'd65536;
         inv_rt_ff    <= 31'd65536;
         i0_ff        <= 31'd65536;
         limit_ff     <= 21'd327680;
         dt_ff        <= 31'd65536;
      end else if (csr_write) begin
         unique case (bvde_pkg::csr_index_type'(csr_index))
            bvde_pkg::CSR_ALPHA_FRAC:          alpha_ff     <= csr_data[15:0];
            bvde_pkg::CSR_INV_ALPHA:           inv_alpha_ff <= csr_data;
            bvde_pkg::CSR_INV_ONE_MINUS_ALPHA: inv_oma_ff   <= csr_data;
            bvde_pkg::CSR_THERMAL_SCALE:       rt_ff        <= csr_data[30:0];
            bvde_pkg::CSR_INV_THERMAL_SCALE:   inv_rt_ff    <= csr_data[30:0];
            bvde_pkg::CSR_EXCHANGE_CURRENT:    i0_ff        <= csr_data[30:0];
            bvde_pkg::CSR_LINEAR_LIMIT:        limit_ff     <= csr_data[20:0];
            bvde_pkg::CSR_TIME_STEP:           dt_ff        <= csr_data[30:0];
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_valid;
         for (int i = 2; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   // stage 1: x = eta / RT
   assign x_in = 63'(req_overpotential) * 63'($signed({1'b0, inv_rt_ff}));

   // stage 2: clamp to the band
   always_comb begin
      lim = (limit_ff > bvde_pkg::LIMIT_CAP) ? bvde_pkg::LIMIT_CAP : limit_ff;
      edge_pos = {27'd0, lim, 16'd0};
      edge_neg = -edge_pos;
      x_ext = 64'(x_ff);
      priority if (x_ext > edge_pos) begin
         region_in = bvde_pkg::REGION_ABOVE;
         u_in = edge_pos;
         d_in = x_ext - edge_pos;
      end else if (x_ext < edge_neg) begin
         region_in = bvde_pkg::REGION_BELOW;
         u_in = edge_neg;
         d_in = x_ext + edge_pos;
      end else begin
         region_in = bvde_pkg::REGION_INSIDE;
         u_in = x_ext;
         d_in = 64'sd0;
      end
   end

   // stage 3: exponent arguments
   always_comb begin
      u_neg = u_ff[63];
      u_abs = u_neg ? -u_ff : u_ff;
      u_mag = u_abs[36:0];
      cm = 17'h10000 - 17'(alpha_ff);
      pa1 = 53'(alpha_ff) * 53'(u_mag);
      pa2 = 54'(cm) * 54'(u_mag);
      a1_in = u_neg ? -$signed(40'(pa1[52:16])) : $signed(40'(pa1[52:16]));
      a2_in = u_neg ? $signed(40'(pa2[53:16])) : -$signed(40'(pa2[53:16]));
   end

   bvde_exp_unit #(.EXP_FRAC_BITS(EXP_FRAC_BITS)) u_exp1 (
      .clock(clock), .enable(adv), .arg(a1_ff), .value(e1)
   );
   bvde_exp_unit #(.EXP_FRAC_BITS(EXP_FRAC_BITS)) u_exp2 (
      .clock(clock), .enable(adv), .arg(a2_ff), .value(e2)
   );

   // stage 15: curvature and edge slope
   always_comb begin
      pg1 = 80'(e1) * 80'(alpha_ff);
      pg2 = 80'(e2) * 80'(cm);
      g2_in = pg1[79:16] + pg2[79:16];
      diff_in = e1 - e2;
   end

   bvde_mul_sat u_base1 (
      .clock(clock), .enable(adv), .op_a(e1), .op_b({32'd0, inv_alpha_ff}),
      .shift(6'd16), .result(b1)
   );
   bvde_mul_sat u_base2 (
      .clock(clock), .enable(adv), .op_a(e2), .op_b({32'd0, inv_oma_ff}),
      .shift(6'd16), .result(b2)
   );
   bvde_mul_sat u_slope (
      .clock(clock), .enable(adv), .op_a(g2_ff[15]), .op_b(d_ff[15]),
      .shift(6'd32), .result(slope)
   );
   bvde_mul_sat u_diffd (
      .clock(clock), .enable(adv), .op_a(diff_ff[15]), .op_b(d_ff[15]),
      .shift(6'd32), .result(diffd)
   );
   bvde_mul_sat u_half (
      .clock(clock), .enable(adv), .op_a(slope.value), .op_b(d_ff[17]),
      .shift(6'd33), .result(half)
   );

   assign bsum = bvde_pkg::add_sat(b1.value, b2.value);
   assign g1s  = bvde_pkg::add_sat(diff_ff[17], slope.value);
   assign g0as = bvde_pkg::add_sat(base_ff, diffd.value);
   assign g0s  = bvde_pkg::add_sat(g0a_ff[19], half.value);

   bvde_mul_sat u_fin0 (
      .clock(clock), .enable(adv), .op_a(g0_ff), .op_b(s0_ff),
      .shift(6'd32), .result(fin0)
   );
   bvde_mul_sat u_fin1 (
      .clock(clock), .enable(adv), .op_a(g1_ff[20]), .op_b(s1_ff),
      .shift(6'd32), .result(fin1)
   );
   bvde_mul_sat u_fin2 (
      .clock(clock), .enable(adv), .op_a(g2_ff[20]), .op_b(s2_ff),
      .shift(6'd32), .result(fin2)
   );

   // scale factors, free running from the registers
   assign pr_s = $signed({2'd0, pr_ff});

   bvde_mul_sat u_sc0 (
      .clock(clock), .enable(1'b1), .op_a(pr_s), .op_b({33'd0, rt_ff}),
      .shift(6'd16), .result(sc0)
   );
   bvde_mul_sat u_sc2 (
      .clock(clock), .enable(1'b1), .op_a(pr_s), .op_b({33'd0, inv_rt_ff}),
      .shift(6'd16), .result(sc2)
   );

   always_ff @(posedge clock) begin
      pr_ff  <= 62'(dt_ff) * 62'(i0_ff);
      s0_ff  <= -sc0.value;
      s0f_ff <= sc0.sat;
      s1_ff  <= -pr_s;
      s2_ff  <= -sc2.value;
      s2f_ff <= sc2.sat;
   end

   assign sat_in = (mask_ff[LAST][0] & (f0_ff[LAST] | fin0.sat | s0f_ff))
                 | (mask_ff[LAST][1] & (f1_ff[LAST] | fin1.sat))
                 | (mask_ff[LAST][2] & (fin2.sat | s2f_ff));

   // datapath registers; advance together
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
         mask_ff[1] <= req_want_mask;
         for (int i = 2; i <= LAST; i++) begin
            mask_ff[i] <= mask_ff[i-1];
         end
         u_ff <= u_in;
         d_ff[2] <= d_in;
         region_ff[2] <= region_in;
         for (int i = 3; i <= 17; i++) begin
            d_ff[i] <= d_ff[i-1];
         end
         for (int i = 3; i <= LAST; i++) begin
            region_ff[i] <= region_ff[i-1];
         end
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         g2_ff[15] <= g2_in;
         diff_ff[15] <= diff_in;
         for (int i = 16; i <= 20; i++) begin
            g2_ff[i] <= g2_ff[i-1];
         end
         for (int i = 16; i <= 17; i++) begin
            diff_ff[i] <= diff_ff[i-1];
         end
         base_ff <= bsum.value;
         f0_ff[17] <= b1.sat | b2.sat | bsum.sat;
         g1_ff[18] <= g1s.value;
         g0a_ff[18] <= g0as.value;
         g0a_ff[19] <= g0a_ff[18];
         f0_ff[18] <= f0_ff[17] | diffd.sat | g0as.sat | slope.sat;
         f1_ff[18] <= slope.sat | g1s.sat;
         f0_ff[19] <= f0_ff[18];
         g0_ff <= g0s.value;
         f0_ff[20] <= f0_ff[19] | half.sat | g0s.sat;
         for (int i = 19; i <= 20; i++) begin
            g1_ff[i] <= g1_ff[i-1];
         end
         for (int i = 19; i <= LAST; i++) begin
            f1_ff[i] <= f1_ff[i-1];
         end
         for (int i = 21; i <= LAST; i++) begin
            f0_ff[i] <= f0_ff[i-1];
         end
         r0_ff <= mask_ff[LAST][0] ? fin0.value : 64'sd0;
         r1_ff <= mask_ff[LAST][1] ? fin1.value : 64'sd0;
         r2_ff <= mask_ff[LAST][2] ? fin2.value : 64'sd0;
         rregion_ff <= region_ff[LAST];
         rsat_ff <= sat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_potential_value = r0_ff;
   assign rsp_first_derivative = r1_ff;
   assign rsp_second_derivative = r2_ff;
   assign rsp_region = rregion_ff;
   assign rsp_saturated = rsat_ff;

endmodule
